[hw/rtl/bbf_pkg.sv]
// bbf_pkg: shared constants, types and helpers of the band beat LED fader.
// No dependencies; used by the interfaces, the lane, the serializer and the top level.
package bbf_pkg;

    localparam int NUM_BANDS = 5;
    localparam int BAND_W    = 3;
    localparam int MAG_W     = 31;
    localparam int LEVEL_W   = 14;
    localparam int TRK_W     = 16;
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int TIME_W    = 32;
    localparam int PERIOD_W  = 16;
    localparam int CFG_IDX_W = 3;

    // level = mag / 200000 = (mag >> 6) / 3125, done as a reciprocal multiply
    localparam int DIV_SHIFT  = 6;
    localparam int DIV_X_W    = MAG_W - DIV_SHIFT;          // 25
    localparam int DIV_PROD_W = 2 * DIV_X_W;                // 50
    localparam int DIV_RSHIFT = 36;
    localparam logic [DIV_X_W-1:0] DIV_MULT = 25'd21990232; // floor(2^36 / 3125)
    localparam logic [DIV_X_W-1:0] DIV_REM  = 25'd3125;

    localparam logic [BAND_W-1:0] BAND_LAST = 3'd4;

    localparam logic [PERIOD_W-1:0] FADE_PERIOD_RST = 16'd33;
    localparam logic [LEVEL_W-1:0]  MIN_LEVEL_RST   = 14'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_PERIOD = 3'd0,
        CFG_MIN_LEVEL   = 3'd1,
        CFG_COLOR0      = 3'd2,
        CFG_COLOR1      = 3'd3,
        CFG_COLOR2      = 3'd4,
        CFG_COLOR3      = 3'd5,
        CFG_COLOR4      = 3'd6
    } t_cfg_idx;

    typedef logic [NUM_BANDS-1:0][COLOR_W-1:0] t_color_arr;

    // per-frame lane strobes
    typedef struct packed {
        logic ld1;    // load divider multiply stage
        logic ld2;    // load level stage
        logic commit; // update tracker and color
        logic fade;   // fade step due this frame
    } t_lane_ctrl;

    // floor(4*c/5) for an 8-bit channel: (c*205) >> 8 is exact over 0..255
    function automatic logic [CHAN_W-1:0] fade_chan(input logic [CHAN_W-1:0] c);
        logic [15:0] p;
        p = 16'(c) * 16'd205;
        return p[15:8];
    endfunction

    function automatic logic [COLOR_W-1:0] fade_color(input logic [COLOR_W-1:0] rgb);
        return {fade_chan(rgb[23:16]), fade_chan(rgb[15:8]), fade_chan(rgb[7:0])};
    endfunction

endpackage

[hw/rtl/bbf_in_if.sv]
// bbf_in_if: input frame channel, five band magnitudes and a millisecond time.
// Depends on bbf_pkg.
interface bbf_in_if;
    logic                         valid;
    logic                         ready;
    logic [bbf_pkg::MAG_W-1:0]    mag_band0;
    logic [bbf_pkg::MAG_W-1:0]    mag_band1;
    logic [bbf_pkg::MAG_W-1:0]    mag_band2;
    logic [bbf_pkg::MAG_W-1:0]    mag_band3;
    logic [bbf_pkg::MAG_W-1:0]    mag_band4;
    logic [bbf_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, mag_band0, mag_band1, mag_band2, mag_band3, mag_band4,
                    now_ms, input ready);
    modport sink   (input valid, mag_band0, mag_band1, mag_band2, mag_band3, mag_band4,
                    now_ms, output ready);
endinterface

[hw/rtl/bbf_out_if.sv]
// bbf_out_if: result channel, one band color per beat.
// Depends on bbf_pkg.
interface bbf_out_if;
    logic                          valid;
    logic                          ready;
    logic [bbf_pkg::BAND_W-1:0]    band_index;
    logic [bbf_pkg::CHAN_W-1:0]    red;
    logic [bbf_pkg::CHAN_W-1:0]    green;
    logic [bbf_pkg::CHAN_W-1:0]    blue;
    logic                          beat_hit;
    logic                          last_band;

    modport source (output valid, band_index, red, green, blue, beat_hit, last_band,
                    input ready);
    modport sink   (input valid, band_index, red, green, blue, beat_hit, last_band,
                    output ready);
endinterface

[hw/rtl/bbf_lane.sv]
// bbf_lane: one band - constant divider pipe, level tracker and band color.
// Depends on bbf_pkg.
module bbf_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bbf_pkg::t_lane_ctrl               i_ctrl,
    input  logic [bbf_pkg::MAG_W-1:0]         i_mag,
    input  logic [bbf_pkg::LEVEL_W-1:0]       i_min_level,
    input  logic [bbf_pkg::COLOR_W-1:0]       i_cfg_color,
    output logic [bbf_pkg::COLOR_W-1:0]       o_color,
    output logic                              o_hit
);
    localparam int XW = bbf_pkg::DIV_X_W;
    localparam int LW = bbf_pkg::LEVEL_W;
    localparam int TW = bbf_pkg::TRK_W;

    logic [XW-1:0]                     r_x1;
    logic [bbf_pkg::DIV_PROD_W-1:0]    r_prod1;
    logic [LW-1:0]                     r_level2;
    logic signed [TW-1:0]              r_trk;
    logic [bbf_pkg::COLOR_W-1:0]       r_color;
    logic                              r_hit;

    logic [LW-1:0]         q0;
    logic [XW-1:0]         qm;
    logic [XW-1:0]         rem;
    logic [LW-1:0]         level;
    logic signed [TW-1:0]  lvl_s;
    logic signed [TW-1:0]  d;
    logic signed [TW-1:0]  step;
    logic signed [TW-1:0]  tn;
    logic                  hit;
    logic signed [TW-1:0]  n_trk;

    // stage 1: reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld1) begin
            r_x1    <= i_mag[bbf_pkg::MAG_W-1:bbf_pkg::DIV_SHIFT];
            r_prod1 <= bbf_pkg::DIV_PROD_W'(i_mag[bbf_pkg::MAG_W-1:bbf_pkg::DIV_SHIFT])
                       * bbf_pkg::DIV_PROD_W'(bbf_pkg::DIV_MULT);
        end
    end

    // stage 2: quotient estimate is exact or one low; fix with remainder
    always_comb begin
        q0    = r_prod1[bbf_pkg::DIV_RSHIFT +: LW];
        qm    = XW'(q0) * bbf_pkg::DIV_REM;
        rem   = r_x1 - qm;
        level = (rem >= bbf_pkg::DIV_REM) ? q0 + LW'(1) : q0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld2) begin
            r_level2 <= level;
        end
    end

    // stage 3: tracker decay toward level, then beat test
    always_comb begin
        lvl_s = signed'({{(TW-LW){1'b0}}, r_level2});
        d     = r_trk - lvl_s;
        step  = (d + (d[TW-1] ? TW'(3) : TW'(0))) >>> 2;  // truncate toward zero
        if (step == '0) begin
            step = TW'(1);
        end
        tn    = r_trk - step;
        hit   = (r_level2 > i_min_level) && (lvl_s > tn);
        n_trk = hit ? lvl_s : tn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk   <= '0;
            r_color <= '0;
            r_hit   <= 1'b0;
        end else if (i_ctrl.commit) begin
            r_trk <= n_trk;
            r_hit <= hit;
            if (hit) begin
                r_color <= i_cfg_color;
            end else if (i_ctrl.fade) begin
                r_color <= bbf_pkg::fade_color(r_color);
            end
        end
    end

    assign o_color = r_color;
    assign o_hit   = r_hit;

endmodule

[hw/rtl/bbf_serializer.sv]
// bbf_serializer: merges the five lane results into one beat per band, band 0 first.
// Depends on bbf_pkg and bbf_out_if.
module bbf_serializer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  bbf_pkg::t_color_arr              i_colors,
    input  logic [bbf_pkg::NUM_BANDS-1:0]    i_hits,
    output logic                             o_free,
    bbf_out_if.source                        o_out
);
    logic                          r_full;
    logic [bbf_pkg::BAND_W-1:0]    r_idx;
    logic                          n_full;
    logic [bbf_pkg::BAND_W-1:0]    n_idx;
    logic                          take;
    logic                          is_last;
    logic [bbf_pkg::COLOR_W-1:0]   sel;

    assign is_last = (r_idx == bbf_pkg::BAND_LAST);
    assign take    = r_full && o_out.ready;
    assign o_free  = !r_full || (take && is_last);

    always_comb begin
        n_full = r_full;
        n_idx  = r_idx;
        if (i_load) begin
            n_full = 1'b1;
            n_idx  = '0;
        end else if (take) begin
            if (is_last) begin
                n_full = 1'b0;
            end else begin
                n_idx = r_idx + bbf_pkg::BAND_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_full <= n_full;
            r_idx  <= n_idx;
        end
    end

    assign sel              = i_colors[r_idx];
    assign o_out.valid      = r_full;
    assign o_out.band_index = r_idx;
    assign o_out.red        = sel[23:16];
    assign o_out.green      = sel[15:8];
    assign o_out.blue       = sel[7:0];
    assign o_out.beat_hit   = i_hits[r_idx];
    assign o_out.last_band  = is_last;

endmodule

[hw/rtl/band_beat_led_fader.sv]
// band_beat_led_fader: beat detector and color fader over five spectrum bands.
// Depends on bbf_pkg, bbf_in_if, bbf_out_if, bbf_lane and bbf_serializer.
// A frame goes through S1 and S2, is committed in S3, then band 0 leaves;
// one beat per band per frame, with the serializer setting the frame rate.
// Reset (synchronous, i_rst_n low): trackers, colors and fade time cleared,
// registers to their defaults, pipeline and serializer empty.
module band_beat_led_fader (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bbf_in_if.sink                           i_in,
    bbf_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [bbf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bbf_pkg::COLOR_W-1:0]      i_cfg_data
);
    // ---------------- configuration registers ----------------
    logic [bbf_pkg::PERIOD_W-1:0]  r_fade_period;
    logic [bbf_pkg::LEVEL_W-1:0]   r_min_level;
    bbf_pkg::t_color_arr           r_cfg_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_period <= bbf_pkg::FADE_PERIOD_RST;
            r_min_level   <= bbf_pkg::MIN_LEVEL_RST;
            r_cfg_color   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                bbf_pkg::CFG_FADE_PERIOD:
                    r_fade_period <= i_cfg_data[bbf_pkg::PERIOD_W-1:0];
                bbf_pkg::CFG_MIN_LEVEL:
                    r_min_level <= i_cfg_data[bbf_pkg::LEVEL_W-1:0];
                bbf_pkg::CFG_COLOR0, bbf_pkg::CFG_COLOR1, bbf_pkg::CFG_COLOR2,
                bbf_pkg::CFG_COLOR3, bbf_pkg::CFG_COLOR4: begin
                    r_cfg_color[i_cfg_idx - bbf_pkg::CFG_COLOR0] <= i_cfg_data;
                end
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // S1: reciprocal multiply, S2: level fix-up, S3: tracker/color commit
    // into the lane registers that also serve as the serializer's frame buffer.
    logic                          r_v1;
    logic                          r_v2;
    logic [bbf_pkg::TIME_W-1:0]    r_now1;
    logic [bbf_pkg::TIME_W-1:0]    r_now2;
    logic [bbf_pkg::TIME_W-1:0]    r_last_fade;

    logic                          fb_free;
    logic                          rdy1;
    logic                          rdy2;
    logic                          ld1;
    logic                          ld2;
    logic                          go3;
    logic                          fade;
    logic [bbf_pkg::TIME_W-1:0]    elapsed;
    bbf_pkg::t_lane_ctrl           lane_ctrl;

    assign rdy2       = !r_v2 || fb_free;
    assign rdy1       = !r_v1 || rdy2;
    assign ld1        = i_in.valid && rdy1;
    assign ld2        = r_v1 && rdy2;
    assign go3        = r_v2 && fb_free;
    assign i_in.ready = rdy1;

    // fade is decided once per frame, wrap-safe elapsed time
    assign elapsed = r_now2 - r_last_fade;
    assign fade    = (elapsed >= bbf_pkg::TIME_W'(r_fade_period));

    assign lane_ctrl.ld1    = ld1;
    assign lane_ctrl.ld2    = ld2;
    assign lane_ctrl.commit = go3;
    assign lane_ctrl.fade   = fade;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_last_fade <= '0;
        end else begin
            if (ld1) begin
                r_v1 <= 1'b1;
            end else if (ld2) begin
                r_v1 <= 1'b0;
            end
            if (ld2) begin
                r_v2 <= 1'b1;
            end else if (go3) begin
                r_v2 <= 1'b0;
            end
            if (go3 && fade) begin
                r_last_fade <= r_now2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_now1 <= i_in.now_ms;
        end
        if (ld2) begin
            r_now2 <= r_now1;
        end
    end

    // ---------------- band lanes ----------------
    logic [bbf_pkg::NUM_BANDS-1:0][bbf_pkg::MAG_W-1:0] mags;
    bbf_pkg::t_color_arr                              lane_color;
    logic [bbf_pkg::NUM_BANDS-1:0]                    lane_hit;

    assign mags = {i_in.mag_band4, i_in.mag_band3, i_in.mag_band2,
                   i_in.mag_band1, i_in.mag_band0};

    for (genvar b = 0; b < bbf_pkg::NUM_BANDS; b++) begin : g_lane
        bbf_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (lane_ctrl),
            .i_mag       (mags[b]),
            .i_min_level (r_min_level),
            .i_cfg_color (r_cfg_color[b]),
            .o_color     (lane_color[b]),
            .o_hit       (lane_hit[b])
        );
    end

    // ---------------- merge: one beat per band ----------------
    bbf_serializer u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (go3),
        .i_colors (lane_color),
        .i_hits   (lane_hit),
        .o_free   (fb_free),
        .o_out    (o_out)
    );

    // ---------------- assertions ----------------
    a_last_is_band4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last_band == (o_out.band_index == bbf_pkg::BAND_LAST)))
        else $error("last_band flag does not match band index");

    a_commit_starts_band0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go3 |=> (o_out.valid && (o_out.band_index == '0)))
        else $error("committed frame does not start at band 0");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_band && !go3) |=> !o_out.valid)
        else $error("output still valid after last beat with no new frame");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && !fb_free) |-> !i_in.ready)
        else $error("input accepted while pipeline is full");

endmodule

[tb/tb_band_beat_led_fader.sv]
`timescale 1ns / 100ps
// tb_band_beat_led_fader: self-checking bench for the five-band beat detector and color fader.
// Depends on bbf_pkg, bbf_in_if, bbf_out_if and band_beat_led_fader; predicts every band color
// beat per frame in a small scoreboard class and checks each one in order.
module tb_band_beat_led_fader;
    import bbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no frame, color beat or register write
    localparam int LONG_HOLD      = 80;    // one long output stall to back up the pipe
    localparam int DRAIN_CYCLES   = 16;    // quiet cycles after the last color beat
    localparam int LEVEL_DIV      = 200000;
    localparam int LEVEL_MAX      = 10737; // level of the largest magnitude
    localparam longint MAG_MAX    = 64'h7FFF_FFFF;
    // index 7 has no register behind it; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    typedef struct packed {
        logic [NUM_BANDS-1:0][MAG_W-1:0] mag;
        logic [TIME_W-1:0]               now_ms;
    } frame_t;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              beat;
        logic              last;
    } band_color_t;

    // Scoreboard: own copy of registers and band state, queue of predicted color beats.
    class band_color_scoreboard;
        int unsigned        fade_period;
        int unsigned        min_level;
        logic [COLOR_W-1:0] beat_color [NUM_BANDS];
        int                 tracker [NUM_BANDS];
        logic [COLOR_W-1:0] shown [NUM_BANDS];
        logic [TIME_W-1:0]  last_fade;
        band_color_t        expected_colors [$];
        int                 mismatches;

        function new();
            fade_period = FADE_PERIOD_RST;
            min_level   = MIN_LEVEL_RST;
            last_fade   = '0;
            mismatches  = 0;
            for (int b = 0; b < NUM_BANDS; b++) begin
                beat_color[b] = '0;
                tracker[b]    = 0;
                shown[b]      = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
            case (idx)
                CFG_FADE_PERIOD: fade_period = data[PERIOD_W-1:0];
                CFG_MIN_LEVEL:   min_level   = data[LEVEL_W-1:0];
                CFG_COLOR0, CFG_COLOR1, CFG_COLOR2, CFG_COLOR3, CFG_COLOR4:
                    beat_color[idx - CFG_COLOR0] = data;
                default: ;
            endcase
        endfunction

        function logic [CHAN_W-1:0] faded(logic [CHAN_W-1:0] c);
            return CHAN_W'((32'(c) * 4) / 5);
        endfunction

        // one accepted frame -> five predicted color beats, band 0 first
        function void note_frame(frame_t f);
            logic              fade_due;
            logic [TIME_W-1:0] elapsed;
            int                level;
            int                step;
            logic              hit;
            band_color_t       r;
            elapsed  = f.now_ms - last_fade;
            fade_due = (elapsed >= fade_period);
            if (fade_due) begin
                last_fade = f.now_ms;
            end
            for (int b = 0; b < NUM_BANDS; b++) begin
                level = int'(f.mag[b]) / LEVEL_DIV;
                // decay toward the level; a zero step still moves by one
                step = (tracker[b] - level) / 4;
                if (step == 0) begin
                    step = 1;
                end
                tracker[b] -= step;
                hit = (level > int'(min_level)) && (level > tracker[b]);
                if (hit) begin
                    tracker[b] = level;
                    shown[b]   = beat_color[b];
                end else if (fade_due) begin
                    shown[b] = {faded(shown[b][23:16]), faded(shown[b][15:8]),
                                faded(shown[b][7:0])};
                end
                r.band  = BAND_W'(b);
                r.red   = shown[b][23:16];
                r.green = shown[b][15:8];
                r.blue  = shown[b][7:0];
                r.beat  = hit;
                r.last  = (b == NUM_BANDS - 1);
                expected_colors.push_back(r);
            end
        endfunction

        task report_mismatch(string what);
            $display("ERROR @%0t: %s", $time, what);
            mismatches++;
        endtask

        task check_field(string name, int band, int unsigned got, int unsigned want);
            if (got != want) begin
                report_mismatch($sformatf("band %0d %s: got %0d, expected %0d",
                                          band, name, got, want));
            end
        endtask

        task check_color(band_color_t got);
            band_color_t want;
            if (expected_colors.size() == 0) begin
                report_mismatch($sformatf("color beat for band %0d with no frame outstanding",
                                          got.band));
                return;
            end
            want = expected_colors.pop_front();
            check_field("band_index", want.band, got.band,  want.band);
            check_field("red",        want.band, got.red,   want.red);
            check_field("green",      want.band, got.green, want.green);
            check_field("blue",       want.band, got.blue,  want.blue);
            check_field("beat_hit",   want.band, got.beat,  want.beat);
            check_field("last_band",  want.band, got.last,  want.last);
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COLOR_W-1:0]   i_cfg_data;

    bbf_in_if  frame_if ();
    bbf_out_if color_if ();

    band_beat_led_fader dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (frame_if),
        .o_out      (color_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    band_color_scoreboard sb;
    int                   quiet_cycles = 0;
    int                   frames_in    = 0;
    bit                   calm         = 1'b0; // end of run: no idling on either side
    logic [TIME_W-1:0]    clock_ms     = '0;   // running millisecond time for random frames

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Monitor: samples both channels at the edge, before any driver update lands.
    // Color beats are checked before the frame of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (color_if.valid && color_if.ready) begin
                sb.check_color({color_if.band_index, color_if.red, color_if.green,
                                color_if.blue, color_if.beat_hit, color_if.last_band});
            end
            if (frame_if.valid && frame_if.ready) begin
                sb.note_frame({frame_if.mag_band4, frame_if.mag_band3, frame_if.mag_band2,
                               frame_if.mag_band1, frame_if.mag_band0, frame_if.now_ms});
                frames_in <= frames_in + 1;
            end
        end
        if ((frame_if.valid && frame_if.ready) || (color_if.valid && color_if.ready) ||
            i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: a run that stops moving beats for too long is a failure.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("band_beat_led_fader: mismatch");
        $finish;
    end

    // Receiver: random short stalls, plus one long hold-off once traffic is flowing
    // so the pipe fills and frame_if.ready drops while frames are still offered.
    initial begin
        bit long_hold_done;
        long_hold_done = 1'b0;
        color_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && frames_in >= 30) begin
                long_hold_done = 1'b1;
                color_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                color_if.ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                color_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                color_if.ready <= 1'b1;
            end else begin
                color_if.ready <= 1'b1;
            end
        end
    end

    // Offer one frame and hold it until accepted; unless calm, may idle first.
    // Called and returns on a rising edge.
    task automatic send_frame(frame_t f);
        if (!calm && $urandom_range(0, 4) == 0) begin
            frame_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        frame_if.valid     <= 1'b1;
        frame_if.mag_band0 <= f.mag[0];
        frame_if.mag_band1 <= f.mag[1];
        frame_if.mag_band2 <= f.mag[2];
        frame_if.mag_band3 <= f.mag[3];
        frame_if.mag_band4 <= f.mag[4];
        frame_if.now_ms    <= f.now_ms;
        @(posedge i_clk);
        while (!frame_if.ready) @(posedge i_clk);
    endtask

    // Stop offering and wait for every predicted color beat to come out.
    task automatic drain();
        frame_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_colors.size() != 0);
    endtask

    // Register write; the caller drops i_cfg_we after the last one of a batch.
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic logic [COLOR_W-1:0] random_color();
        case ($urandom_range(0, 3))
            0:       return 24'hFF_FFFF;
            1:       return 24'h00_0000;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    // Full register set: fade period, min level and fresh beat colors.
    // Only called with nothing in flight.
    task automatic load_settings(logic [COLOR_W-1:0] fade_word, logic [COLOR_W-1:0] min_word);
        set_reg(CFG_FADE_PERIOD, fade_word);
        set_reg(CFG_MIN_LEVEL, min_word);
        for (int b = 0; b < NUM_BANDS; b++) begin
            set_reg(CFG_COLOR0 + CFG_IDX_W'(b), random_color());
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic frame_t frame_of(logic [MAG_W-1:0] m0, logic [MAG_W-1:0] m1,
                                        logic [MAG_W-1:0] m2, logic [MAG_W-1:0] m3,
                                        logic [MAG_W-1:0] m4, logic [TIME_W-1:0] t);
        frame_t f;
        f.mag    = {m4, m3, m2, m1, m0};
        f.now_ms = t;
        return f;
    endfunction

    // Random frame: mostly music-like levels, many close to the band's tracker or to
    // the beat threshold, some silence and some raw noise. Time mostly creeps forward,
    // sometimes by about one fade period, sometimes jumps anywhere.
    function automatic frame_t random_frame();
        frame_t f;
        int     lvl;
        longint m;
        int     step;
        for (int b = 0; b < NUM_BANDS; b++) begin
            lvl = -1;
            m   = 0;
            case ($urandom_range(0, 9))
                0, 1, 2: m = $urandom_range(0, 999999);
                3, 4, 5: lvl = $urandom_range(0, 400);
                6, 7:    lvl = sb.tracker[b] + int'($urandom_range(0, 6)) - 3;
                8:       m = longint'($urandom) & MAG_MAX;
                default: lvl = int'(sb.min_level) + int'($urandom_range(0, 2));
            endcase
            if (lvl >= 0 || m == 0 && lvl != -1) begin
                if (lvl < 0) lvl = 0;
                if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
                // land on either edge of the level or anywhere inside it
                case ($urandom_range(0, 2))
                    0:       m = longint'(lvl) * LEVEL_DIV;
                    1:       m = longint'(lvl) * LEVEL_DIV + LEVEL_DIV - 1;
                    default: m = longint'(lvl) * LEVEL_DIV + $urandom_range(0, LEVEL_DIV - 1);
                endcase
            end
            if (m > MAG_MAX) m = MAG_MAX;
            f.mag[b] = MAG_W'(m);
        end
        case ($urandom_range(0, 19))
            14, 15, 16: step = int'(sb.fade_period) + int'($urandom_range(0, 2)) - 1;
            17, 18: begin
                clock_ms = $urandom;
                step     = 0;
            end
            19:      step = 0;
            default: step = $urandom_range(0, 50);
        endcase
        clock_ms = clock_ms + TIME_W'(step);
        f.now_ms = clock_ms;
        return f;
    endfunction

    task automatic run_random(int count, int calm_from);
        for (int i = 0; i < count; i++) begin
            if (i == calm_from) calm = 1'b1;
            send_frame(random_frame());
        end
        drain();
    endtask

    initial begin
        sb = new();
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_FADE_PERIOD;
        i_cfg_data         <= '0;
        frame_if.valid     <= 1'b0;
        frame_if.mag_band0 <= '0;
        frame_if.mag_band1 <= '0;
        frame_if.mag_band2 <= '0;
        frame_if.mag_band3 <= '0;
        frame_if.mag_band4 <= '0;
        frame_if.now_ms    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: default period and threshold, explicit edges ----
        load_settings(24'd33, 24'd3);
        // silence at time zero: no fade yet, trackers drift below zero
        send_frame(frame_of(0, 0, 0, 0, 0, 32'd0));
        // level equal to min_level vs one above it; fade due at exactly one period
        send_frame(frame_of(31'd799999, 31'd800000, 31'd0, 31'h7FFF_FFFF, 31'd1, 32'd33));
        // full scale on all bands, then again: tracker moves by the forced single step
        send_frame(frame_of('1, '1, '1, '1, '1, 32'd34));
        send_frame(frame_of('1, '1, '1, '1, '1, 32'd66));
        // quiet frames: fade on, one short of a period, then due again
        send_frame(frame_of(0, 0, 0, 0, 0, 32'd99));
        send_frame(frame_of(0, 0, 0, 0, 0, 32'd131));
        send_frame(frame_of(0, 0, 0, 0, 0, 32'd132));
        // time wrap: far jump fades, then 32 ms across the wrap does not, 33 does
        send_frame(frame_of(0, 0, 0, 0, 0, 32'hFFFF_FFF0));
        send_frame(frame_of(0, 0, 0, 0, 0, 32'h0000_0010));
        send_frame(frame_of(0, 0, 0, 0, 0, 32'h0000_0011));
        // level boundaries and alternating bit patterns, time all ones
        send_frame(frame_of(31'd199999, 31'd200000, 31'h5555_5555, 31'h2AAA_AAAA, '1,
                            32'hFFFF_FFFF));
        drain();

        // zero fade period: fade every frame; junk above the register widths is dropped
        set_reg(CFG_IDX_SPARE, 24'hFF_FFFF);
        load_settings({8'hA5, 16'd0}, {10'h3FF, 14'd0});
        send_frame(frame_of(0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_frame(frame_of(31'd200000, 31'd200000, 31'd200000, 31'd200000, 31'd200000,
                            32'hFFFF_FFFF));
        send_frame(frame_of(31'd400000, '1, 31'd0, 31'd600000, 31'd399999, 32'd5));
        drain();

        // ---- random phases over a spread of settings ----
        clock_ms = 32'd1000;
        load_settings(24'd1, 24'd0);
        run_random(25, -1);

        load_settings(24'd65535, 24'(LEVEL_MAX));
        run_random(20, -1);

        set_reg(CFG_IDX_SPARE, COLOR_W'($urandom));
        load_settings(24'($urandom_range(2, 100)), {10'($urandom), 14'($urandom_range(0, 40))});
        run_random(25, -1);

        clock_ms = 32'hFFFF_FF00;
        load_settings(24'($urandom_range(1, 60)), 24'($urandom_range(0, 20)));
        run_random(30, 10);

        // catch any stray color beat after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("band_beat_led_fader: match");
        end else begin
            $display("band_beat_led_fader: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/bbf_pkg.sv
hw/rtl/bbf_in_if.sv
hw/rtl/bbf_out_if.sv
hw/rtl/bbf_lane.sv
hw/rtl/bbf_serializer.sv
hw/rtl/band_beat_led_fader.sv
tb/tb_band_beat_led_fader.sv
